// ===== src/random_column_permutation_top_macros.svh =====
// Assertion macros used by the checker file of the column permutation block.
`ifndef RANDOM_COLUMN_PERMUTATION_TOP_MACROS_SVH
`define RANDOM_COLUMN_PERMUTATION_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rcp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rcp assertion failed");

`endif

// ===== src/rcp_pkg.sv =====
package rcp_pkg;

   localparam int CHUNK_SIZE_DEFAULT = 32;

   localparam logic [31:0] SEED_AT_RESET = 32'd2463534242;
   localparam logic [31:0] RESEED_MUL    = 32'd2654435761;

   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 17;
   localparam int XS_SHIFT_C = 5;

   localparam logic CMD_RESEED  = 1'b0;
   localparam logic CMD_SHUFFLE = 1'b1;

   typedef struct packed {
      logic load;
      logic tick_inc;
      logic mix;
      logic fill_wr;
      logic k_clr;
      logic k_inc;
      logic i_init;
      logic i_dec;
      logic rng_step;
      logic div_step;
      logic rd_swap;
      logic wr_i;
      logic wr_j;
      logic emit_rd;
      logic out_load;
      logic err_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_shuffle;
      logic n_zero;
      logic n_one;
      logic range_err;
      logic k_last;
      logic i_one;
      logic div_last;
      logic out_free;
   } ctrl_sts_type;

   function automatic logic [31:0] xorshift32(input logic [31:0] x);
      logic [31:0] a;
      logic [31:0] b;
      a = x ^ (x << XS_SHIFT_A);
      b = a ^ (a >> XS_SHIFT_B);
      return b ^ (b << XS_SHIFT_C);
   endfunction

endpackage

// ===== src/rcp_controller.sv =====
module rcp_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rcp_pkg::ctrl_sts_type sts,
   output rcp_pkg::ctrl_cmd_type cmd
);
   import rcp_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_TICK     = 4'd2;
   localparam logic [3:0] S_MIX      = 4'd3;
   localparam logic [3:0] S_FILL     = 4'd4;
   localparam logic [3:0] S_STEP     = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_READ     = 4'd7;
   localparam logic [3:0] S_WR_I     = 4'd8;
   localparam logic [3:0] S_WR_J     = 4'd9;
   localparam logic [3:0] S_EMIT_RD  = 4'd10;
   localparam logic [3:0] S_EMIT_OUT = 4'd11;
   localparam logic [3:0] S_ERROR    = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (!sts.is_shuffle) begin
               state_in = S_TICK;
            end else if (sts.n_zero) begin
               state_in = S_IDLE;
            end else if (sts.range_err) begin
               state_in = S_ERROR;
            end else begin
               state_in = S_FILL;
            end
         end
         S_TICK: begin
            cmd.tick_inc = 1'b1;
            state_in     = S_MIX;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_IDLE;
         end
         S_FILL: begin
            cmd.fill_wr = 1'b1;
            if (sts.k_last) begin
               cmd.k_clr  = 1'b1;
               cmd.i_init = 1'b1;
               state_in   = sts.n_one ? S_EMIT_RD : S_STEP;
            end else begin
               cmd.k_inc = 1'b1;
            end
         end
         S_STEP: begin
            cmd.rng_step = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_swap = 1'b1;
            state_in    = S_WR_I;
         end
         S_WR_I: begin
            cmd.wr_i = 1'b1;
            state_in = S_WR_J;
         end
         S_WR_J: begin
            cmd.wr_j  = 1'b1;
            cmd.i_dec = 1'b1;
            state_in  = sts.i_one ? S_EMIT_RD : S_STEP;
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.k_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_EMIT_RD;
               end
            end
         end
         S_ERROR: begin
            if (sts.out_free) begin
               cmd.err_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/rcp_datapath.sv =====
module rcp_datapath #(
   parameter int CHUNK_SIZE = rcp_pkg::CHUNK_SIZE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rcp_pkg::ctrl_cmd_type cmd,
   output rcp_pkg::ctrl_sts_type sts,
   input  logic                  req_command,
   input  logic [15:0]           req_first_column,
   input  logic [5:0]            req_count,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_column,
   output logic                  rsp_last,
   output logic                  rsp_range_error
);
   import rcp_pkg::*;

   localparam int IDX_W = $clog2(CHUNK_SIZE);
   localparam int CNT_W = $clog2(CHUNK_SIZE + 1);

   logic [31:0]      rng_ff;
   logic [31:0]      tick_ff;
   logic             cmd_ff;
   logic [15:0]      first_ff;
   logic [CNT_W-1:0] n_ff;
   logic [CNT_W-1:0] n_in;
   logic [IDX_W-1:0] k_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [31:0]      div_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [4:0]       div_cnt_ff;
   logic [CNT_W-1:0] divisor;
   logic [CNT_W:0]   rem_sh;
   logic [31:0]      rng_next;
   logic [31:0]      mix_prod;

   logic [15:0]      mem [CHUNK_SIZE];
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   logic [15:0]      mem_wr_data;
   logic [IDX_W-1:0] rd_a_addr;
   logic [IDX_W-1:0] j_addr;
   logic [15:0]      rd_a_ff;
   logic [15:0]      rd_b_ff;

   logic             rsp_valid_ff;
   logic [15:0]      rsp_column_ff;
   logic             rsp_last_ff;
   logic             rsp_err_ff;

   assign n_in = ({1'b0, req_count} > 7'(CHUNK_SIZE)) ? CNT_W'(CHUNK_SIZE)
                                                      : CNT_W'(req_count);
   assign rng_next = xorshift32(rng_ff);
   assign mix_prod = 32'(tick_ff * RESEED_MUL);
   assign divisor  = CNT_W'(idx_ff) + CNT_W'(1);
   assign rem_sh   = {rem_ff, div_ff[31]};
   assign j_addr   = IDX_W'(rem_ff);

   assign sts.is_shuffle = (cmd_ff == CMD_SHUFFLE);
   assign sts.n_zero     = (n_ff == '0);
   assign sts.n_one      = (n_ff == CNT_W'(1));
   assign sts.range_err  = ({1'b0, first_ff} + 17'(n_ff)) > 17'h10000;
   assign sts.k_last     = (CNT_W'(k_ff) == (n_ff - CNT_W'(1)));
   assign sts.i_one      = (idx_ff == IDX_W'(1));
   assign sts.div_last   = (div_cnt_ff == 5'd31);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_ff  <= SEED_AT_RESET;
         tick_ff <= '0;
      end else begin
         priority if (csr_wr_en) begin
            rng_ff <= csr_wr_data;
         end else if (cmd.mix) begin
            rng_ff <= rng_ff ^ mix_prod;
         end else if (cmd.rng_step) begin
            rng_ff <= rng_next;
         end
         if (cmd.tick_inc) begin
            tick_ff <= tick_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_command;
         first_ff <= req_first_column;
         n_ff     <= n_in;
      end
      priority if (cmd.load || cmd.k_clr) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + IDX_W'(1);
      end
      priority if (cmd.i_init) begin
         idx_ff <= IDX_W'(n_ff - CNT_W'(1));
      end else if (cmd.i_dec) begin
         idx_ff <= idx_ff - IDX_W'(1);
      end
      priority if (cmd.rng_step) begin
         div_ff     <= rng_next;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_ff     <= {div_ff[30:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + 5'd1;
         if (rem_sh >= {1'b0, divisor}) begin
            rem_ff <= CNT_W'(rem_sh - {1'b0, divisor});
         end else begin
            rem_ff <= CNT_W'(rem_sh);
         end
      end
   end

   always_comb begin
      mem_wr_en   = cmd.fill_wr || cmd.wr_i || cmd.wr_j;
      mem_wr_addr = k_ff;
      mem_wr_data = first_ff + 16'(k_ff);
      priority if (cmd.wr_i) begin
         mem_wr_addr = idx_ff;
         mem_wr_data = rd_b_ff;
      end else if (cmd.wr_j) begin
         mem_wr_addr = j_addr;
         mem_wr_data = rd_a_ff;
      end else begin
         mem_wr_addr = k_ff;
      end
   end

   assign rd_a_addr = cmd.emit_rd ? k_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (cmd.rd_swap || cmd.emit_rd) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (cmd.rd_swap) begin
         rd_b_ff <= mem[j_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.err_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_column_ff <= rd_a_ff;
         rsp_last_ff   <= sts.k_last;
         rsp_err_ff    <= 1'b0;
      end else if (cmd.err_load) begin
         rsp_column_ff <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_err_ff    <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

// ===== src/random_column_permutation_top.sv =====
// Random column permutation: a reseed request (command 0) steps the tick counter, mixes it
// into the generator and gives no response. A shuffle request (command 1) with n columns,
// n saturated to CHUNK_SIZE, fills the buffer and then runs n - 1 swap steps. Each swap
// step is set by the remainder unit, which retires one bit of the 32-bit generator value
// per cycle, followed by a read and two writes on the single-write permutation buffer;
// each emitted column takes a buffer read and an output register load. A zero count ends
// at decode with no response, a range error with a single error response. Requests are
// taken one at a time; the next one is accepted while the final response still waits in
// the output register. Writing the seed register loads the generator directly and must be
// done while the block is idle.
module random_column_permutation_top #(
   parameter int CHUNK_SIZE = rcp_pkg::CHUNK_SIZE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [15:0] req_first_column,
   input  logic [5:0]  req_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_column,
   output logic        rsp_last,
   output logic        rsp_range_error,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import rcp_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   rcp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rcp_datapath #(
      .CHUNK_SIZE (CHUNK_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_command      (req_command),
      .req_first_column (req_first_column),
      .req_count        (req_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column       (rsp_column),
      .rsp_last         (rsp_last),
      .rsp_range_error  (rsp_range_error)
   );

endmodule

// ===== src/rcp_checker.sv =====
`include "random_column_permutation_top_macros.svh"

module rcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_column,
   input logic        rsp_last,
   input logic        rsp_range_error
);

   `RCP_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && rsp_stall, rsp_valid)
   `RCP_ASSERT_SAME(a_error_is_last, rsp_valid && rsp_range_error, rsp_last)
   `RCP_ASSERT_SAME(a_error_column_zero, rsp_valid && rsp_range_error, rsp_column == 16'd0)
   `RCP_ASSERT_NEXT(a_busy_after_request, req_valid && !req_stall, req_stall)

endmodule

bind random_column_permutation_top rcp_checker u_rcp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_column      (rsp_column),
   .rsp_last        (rsp_last),
   .rsp_range_error (rsp_range_error)
);

// ===== dv/random_column_permutation_top_tb.sv =====
module random_column_permutation_top_tb;
   import rcp_pkg::*;

   localparam int CHUNK = CHUNK_SIZE_DEFAULT;
   localparam int SETTLE_CYCLES = 20;
   localparam int ITEMS_PER_PHASE = 52;
   localparam int N_DIRECTED = 16;

   typedef struct packed {
      logic [15:0] column;
      logic        last;
      logic        range_error;
   } column_result_type;

   typedef struct packed {
      logic        command;
      logic [15:0] first_column;
      logic [5:0]  count;
      logic        typed;
      logic [15:0] column;
      logic        last;
      logic        range_error;
   } request_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_RESEED;
   logic [15:0] req_first_column = '0;
   logic [5:0]  req_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_column;
   logic        rsp_last;
   logic        rsp_range_error;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   logic [31:0] perm_rng = SEED_AT_RESET;
   logic [31:0] perm_ticks = '0;

   column_result_type pending_columns[$];
   column_result_type next_columns[$];
   int mismatch_count = 0;
   int stall_pct = 0;
   int gap_pct = 0;
   int stall_left = 0;

   request_row_type directed_requests [N_DIRECTED] = '{
      '{CMD_SHUFFLE, 16'd100,   6'd1,  1'b1, 16'd100,   1'b1, 1'b0},
      '{CMD_SHUFFLE, 16'd0,     6'd1,  1'b1, 16'd0,     1'b1, 1'b0},
      '{CMD_SHUFFLE, 16'd65535, 6'd1,  1'b1, 16'd65535, 1'b1, 1'b0},
      '{CMD_SHUFFLE, 16'd1234,  6'd0,  1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_SHUFFLE, 16'd65535, 6'd2,  1'b1, 16'd0,     1'b1, 1'b1},
      '{CMD_SHUFFLE, 16'd65505, 6'd32, 1'b1, 16'd0,     1'b1, 1'b1},
      '{CMD_SHUFFLE, 16'd65520, 6'd63, 1'b1, 16'd0,     1'b1, 1'b1},
      '{CMD_SHUFFLE, 16'd65504, 6'd32, 1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_SHUFFLE, 16'd0,     6'd63, 1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_SHUFFLE, 16'd1000,  6'd2,  1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_RESEED,  16'hFFFF,  6'd63, 1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_SHUFFLE, 16'h5555,  6'd31, 1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_RESEED,  16'd0,     6'd0,  1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_SHUFFLE, 16'hAAAA,  6'd33, 1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_SHUFFLE, 16'h8000,  6'd16, 1'b0, 16'd0,     1'b0, 1'b0},
      '{CMD_SHUFFLE, 16'd65535, 6'd0,  1'b0, 16'd0,     1'b0, 1'b0}
   };

   random_column_permutation_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_first_column (req_first_column),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column       (rsp_column),
      .rsp_last         (rsp_last),
      .rsp_range_error  (rsp_range_error),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(60, 12);
      return $urandom_range(4, 1);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Computes the columns that one request yields and advances the generator state.
   task automatic predict_permutation(input logic cmd, input logic [15:0] first,
                                      input logic [5:0] cnt);
      logic [15:0] order [CHUNK];
      logic [15:0] swap;
      logic [31:0] x;
      column_result_type res;
      int n;
      int i;
      int j;
      next_columns.delete();
      if (cmd == CMD_RESEED) begin
         perm_ticks = perm_ticks + 32'd1;
         perm_rng = perm_rng ^ (perm_ticks * RESEED_MUL);
         return;
      end
      n = (cnt > CHUNK) ? CHUNK : int'(cnt);
      if (n == 0) return;
      if (int'(first) + n > 65536) begin
         res = '{column: 16'd0, last: 1'b1, range_error: 1'b1};
         next_columns = {next_columns, res};
         return;
      end
      for (i = 0; i < n; i++) order[i] = first + 16'(i);
      for (i = n - 1; i > 0; i--) begin
         x = perm_rng;
         x = x ^ (x << XS_SHIFT_A);
         x = x ^ (x >> XS_SHIFT_B);
         x = x ^ (x << XS_SHIFT_C);
         perm_rng = x;
         j = int'(x % 32'(i + 1));
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (i = 0; i < n; i++) begin
         res = '{column: order[i], last: (i == n - 1), range_error: 1'b0};
         next_columns = {next_columns, res};
      end
   endtask

   task automatic drive_request(input logic cmd, input logic [15:0] first,
                                input logic [5:0] cnt);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_first_column <= first;
      req_count <= cnt;
      do @(posedge clock); while (req_stall);
      predict_permutation(cmd, first, cnt);
   endtask

   task automatic queue_predicted();
      pending_columns = {pending_columns, next_columns};
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_columns.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      perm_rng = value;
   endtask

   always @(posedge clock) begin : stall_gen
      int gap;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         gap = pick_gap(stall_pct);
         rsp_stall <= (gap != 0);
         stall_left <= (gap > 0) ? gap - 1 : 0;
      end
   end

   always @(posedge clock) begin : response_check
      column_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_columns.size() == 0) begin
            report_mismatch($sformatf("column %0d arrived with nothing pending", rsp_column));
         end else begin
            want = pending_columns.pop_front();
            if (rsp_column !== want.column)
               report_mismatch($sformatf("column %0d, wanted %0d", rsp_column, want.column));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, wanted %b", rsp_last, want.last));
            if (rsp_range_error !== want.range_error)
               report_mismatch($sformatf("range_error %b, wanted %b",
                                         rsp_range_error, want.range_error));
         end
      end
   end

   initial begin
      #20000000;
      $display("FAIL random_column_permutation_top");
      $finish;
   end

   initial begin
      logic [31:0] seeds [6];
      request_row_type row;
      column_result_type typed_result;
      logic cmd;
      logic [15:0] first;
      logic [5:0] cnt;
      int counted;
      int roll;
      seeds = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, $urandom, $urandom,
                SEED_AT_RESET};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_DIRECTED; r++) begin
         row = directed_requests[r];
         drive_request(row.command, row.first_column, row.count);
         if (row.typed) begin
            typed_result = '{column: row.column, last: row.last,
                             range_error: row.range_error};
            pending_columns = {pending_columns, typed_result};
         end else begin
            queue_predicted();
         end
      end

      // With a zero seed every swap index is zero until a reseed request.
      drain_and_settle();
      write_seed(32'h0);
      drive_request(CMD_SHUFFLE, 16'd200, 6'd6);
      queue_predicted();
      drive_request(CMD_RESEED, 16'h1234, 6'd9);
      queue_predicted();
      drive_request(CMD_SHUFFLE, 16'd300, 6'd5);
      queue_predicted();

      for (int p = 0; p < 6; p++) begin
         drain_and_settle();
         write_seed(seeds[p]);
         stall_pct = (p == 0) ? 0 : $urandom_range(50, 5);
         gap_pct = (p == 0) ? 0 : $urandom_range(50, 5);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if ($urandom_range(39) == 0) drain_and_settle();
            roll = $urandom_range(99);
            first = (roll % 10 == 0) ? 16'($urandom_range(65535, 65500))
                                     : 16'($urandom_range(65535, 0));
            cmd = (roll < 15) ? CMD_RESEED : CMD_SHUFFLE;
            roll = $urandom_range(99);
            if (roll < 5) cnt = 6'd0;
            else if (roll < 50) cnt = 6'($urandom_range(8, 1));
            else if (roll < 75) cnt = 6'($urandom_range(31, 9));
            else if (roll < 88) cnt = 6'd32;
            else cnt = 6'($urandom_range(63, 33));
            drive_request(cmd, first, cnt);
            queue_predicted();
            if (cmd == CMD_RESEED || cnt != 6'd0) counted++;
            idle_gap(pick_gap(gap_pct));
         end
      end

      drain_and_settle();
      if (mismatch_count == 0)
         $display("PASS random_column_permutation_top");
      else
         $display("FAIL random_column_permutation_top");
      $finish;
   end

endmodule
